/* src/rmj_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmj_pkg
// Shared widths, stage counts and the per-item context record of the radar
// measurement Jacobian pipeline.
// ----------------------------------------------------------------------------
package rmj_pkg;

  localparam int IN_W       = 24;          // Q7.16 state fields
  localparam int FRAC       = 16;          // fraction bits
  localparam int OUT_W      = 32;          // Q15.16 Jacobian entries
  localparam int CFG_W      = 16;
  localparam logic [CFG_W-1:0] CFG_RESET = 16'd655;

  localparam int SQ_W       = 2 * IN_W;    // squared range
  localparam int CM_W       = 2 * IN_W;    // magnitude of vx*py - vy*px
  localparam int R_W        = IN_W;        // range, floor(sqrt(S))
  localparam int HALF_W     = SQ_W / 2;    // split point of the wide products
  localparam int RS_W       = R_W + SQ_W;  // range cubed
  localparam int SQRT_STEPS = SQ_W / 2;
  localparam int SQRT_RW    = R_W + 2;     // root remainder

  localparam int DIV_NW     = 88;          // numerator
  localparam int DIV_DW     = RS_W;        // denominator
  localparam int DIV_QW     = OUT_W;       // quotient bits produced
  localparam int DIV_HW     = DIV_NW - DIV_QW;
  localparam int DIV_LAT    = DIV_QW + 1;
  localparam int N_ENT      = 6;

  typedef struct packed {
    logic             sing;
    logic             px_neg;
    logic             py_neg;
    logic             cneg;
    logic [IN_W-1:0]  mx;
    logic [IN_W-1:0]  my;
    logic [CM_W-1:0]  cmag;
    logic [SQ_W-1:0]  s;
  } ctx_t;

endpackage

/* src/rmj_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmj_front
// Two stages: squares and cross products, then squared range, cross term
// magnitude and the near-zero range check.
// ----------------------------------------------------------------------------
module rmj_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic                             in_vld,
  input  logic signed [rmj_pkg::IN_W-1:0]  pos_x,
  input  logic signed [rmj_pkg::IN_W-1:0]  pos_y,
  input  logic signed [rmj_pkg::IN_W-1:0]  vel_x,
  input  logic signed [rmj_pkg::IN_W-1:0]  vel_y,
  input  logic [rmj_pkg::CFG_W-1:0]        thr,
  output logic                             out_vld,
  output rmj_pkg::ctx_t                    out_ctx
);

  logic                            vld1_r, vld2_r;
  logic [rmj_pkg::SQ_W-1:0]        sqx_r, sqy_r;
  logic signed [rmj_pkg::SQ_W-1:0] a_r, b_r;
  logic [rmj_pkg::IN_W-1:0]        mx_r, my_r;
  logic                            nx_r, ny_r;
  rmj_pkg::ctx_t                   ctx_r, ctx_nxt;

  logic signed [rmj_pkg::SQ_W-1:0] sqx_nxt, sqy_nxt, a_nxt, b_nxt;
  logic signed [rmj_pkg::SQ_W:0]   diff;
  logic [rmj_pkg::SQ_W-1:0]        s_sum;
  logic [rmj_pkg::SQ_W:0]          diff_neg;

  always_comb begin
    sqx_nxt = pos_x * pos_x;
    sqy_nxt = pos_y * pos_y;
    a_nxt   = vel_x * pos_y;
    b_nxt   = vel_y * pos_x;
  end

  always_comb begin
    s_sum    = sqx_r + sqy_r;
    diff     = {a_r[rmj_pkg::SQ_W-1], a_r} - {b_r[rmj_pkg::SQ_W-1], b_r};
    diff_neg = -diff;
    ctx_nxt.cneg   = diff[rmj_pkg::SQ_W];
    ctx_nxt.cmag   = diff[rmj_pkg::SQ_W] ? diff_neg[rmj_pkg::CM_W-1:0]
                                         : diff[rmj_pkg::CM_W-1:0];
    ctx_nxt.s      = s_sum;
    ctx_nxt.mx     = mx_r;
    ctx_nxt.my     = my_r;
    ctx_nxt.px_neg = nx_r;
    ctx_nxt.py_neg = ny_r;
    ctx_nxt.sing   = (s_sum == '0) ||
                     (s_sum < rmj_pkg::SQ_W'({thr, {rmj_pkg::FRAC{1'b0}}}));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else if (en) begin
      vld1_r <= in_vld;
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sqx_r <= sqx_nxt;
      sqy_r <= sqy_nxt;
      a_r   <= a_nxt;
      b_r   <= b_nxt;
      mx_r  <= pos_x[rmj_pkg::IN_W-1] ? rmj_pkg::IN_W'(-pos_x) : pos_x;
      my_r  <= pos_y[rmj_pkg::IN_W-1] ? rmj_pkg::IN_W'(-pos_y) : pos_y;
      nx_r  <= pos_x[rmj_pkg::IN_W-1];
      ny_r  <= pos_y[rmj_pkg::IN_W-1];
      ctx_r <= ctx_nxt;
    end
  end

  assign out_vld = vld2_r;
  assign out_ctx = ctx_r;

endmodule

/* src/rmj_sqrt.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmj_sqrt
// Pipelined integer square root of the squared range, one root bit per stage.
// ----------------------------------------------------------------------------
module rmj_sqrt (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_vld,
  input  rmj_pkg::ctx_t             in_ctx,
  output logic                      out_vld,
  output rmj_pkg::ctx_t             out_ctx,
  output logic [rmj_pkg::R_W-1:0]   root
);

  localparam int N = rmj_pkg::SQRT_STEPS;

  logic [N-1:0]                  vld_r;
  logic [rmj_pkg::SQRT_RW-1:0]   rem_r   [N];
  logic [rmj_pkg::SQRT_RW-1:0]   rem_nxt [N];
  logic [rmj_pkg::R_W-1:0]       root_r  [N];
  logic [rmj_pkg::R_W-1:0]       root_nxt[N];
  logic [rmj_pkg::SQ_W-1:0]      sh_r    [N];
  logic [rmj_pkg::SQ_W-1:0]      sh_nxt  [N];
  rmj_pkg::ctx_t                 ctx_r   [N];

  always_comb begin
    logic [rmj_pkg::SQRT_RW-1:0] r_in, cur, trial;
    logic [rmj_pkg::R_W-1:0]     q_in;
    logic [rmj_pkg::SQ_W-1:0]    s_in;
    for (int k = 0; k < N; k++) begin
      r_in  = (k == 0) ? '0 : rem_r[(k == 0) ? 0 : k-1];
      q_in  = (k == 0) ? '0 : root_r[(k == 0) ? 0 : k-1];
      s_in  = (k == 0) ? in_ctx.s : sh_r[(k == 0) ? 0 : k-1];
      // Bring down the next two radicand bits and try root*4 + 1.
      cur   = {r_in[rmj_pkg::SQRT_RW-3:0], s_in[rmj_pkg::SQ_W-1 -: 2]};
      trial = {q_in, 2'b01};
      if (cur >= trial) begin
        rem_nxt[k]  = cur - trial;
        root_nxt[k] = {q_in[rmj_pkg::R_W-2:0], 1'b1};
      end else begin
        rem_nxt[k]  = cur;
        root_nxt[k] = {q_in[rmj_pkg::R_W-2:0], 1'b0};
      end
      sh_nxt[k] = {s_in[rmj_pkg::SQ_W-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[N-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < N; k++) begin
        rem_r[k]  <= rem_nxt[k];
        root_r[k] <= root_nxt[k];
        sh_r[k]   <= sh_nxt[k];
        ctx_r[k]  <= (k == 0) ? in_ctx : ctx_r[(k == 0) ? 0 : k-1];
      end
    end
  end

  assign out_vld = vld_r[N-1];
  assign out_ctx = ctx_r[N-1];
  assign root    = root_r[N-1];

endmodule

/* src/rmj_mul.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmj_mul
// Wide products range*S and p*C, each built from two half products that are
// registered and then summed in a second stage.
// ----------------------------------------------------------------------------
module rmj_mul (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_vld,
  input  rmj_pkg::ctx_t             in_ctx,
  input  logic [rmj_pkg::R_W-1:0]   in_root,
  output logic                      out_vld,
  output rmj_pkg::ctx_t             out_ctx,
  output logic [rmj_pkg::R_W-1:0]   out_root,
  output logic [rmj_pkg::RS_W-1:0]  rs,
  output logic [rmj_pkg::RS_W-1:0]  pxc,
  output logic [rmj_pkg::RS_W-1:0]  pyc
);

  localparam int H  = rmj_pkg::HALF_W;
  localparam int PW = 2 * H;

  logic                     vld1_r, vld2_r;
  rmj_pkg::ctx_t            ctx1_r, ctx2_r;
  logic [rmj_pkg::R_W-1:0]  root1_r, root2_r;
  logic [PW-1:0]            rs_lo_r, rs_hi_r, xc_lo_r, xc_hi_r, yc_lo_r, yc_hi_r;
  logic [rmj_pkg::RS_W-1:0] rs_r, pxc_r, pyc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else if (en) begin
      vld1_r <= in_vld;
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rs_lo_r <= PW'(in_root * in_ctx.s[H-1:0]);
      rs_hi_r <= PW'(in_root * in_ctx.s[2*H-1:H]);
      xc_lo_r <= PW'(in_ctx.mx * in_ctx.cmag[H-1:0]);
      xc_hi_r <= PW'(in_ctx.mx * in_ctx.cmag[2*H-1:H]);
      yc_lo_r <= PW'(in_ctx.my * in_ctx.cmag[H-1:0]);
      yc_hi_r <= PW'(in_ctx.my * in_ctx.cmag[2*H-1:H]);
      ctx1_r  <= in_ctx;
      root1_r <= in_root;
      rs_r    <= rmj_pkg::RS_W'(rs_lo_r) + rmj_pkg::RS_W'({rs_hi_r, {H{1'b0}}});
      pxc_r   <= rmj_pkg::RS_W'(xc_lo_r) + rmj_pkg::RS_W'({xc_hi_r, {H{1'b0}}});
      pyc_r   <= rmj_pkg::RS_W'(yc_lo_r) + rmj_pkg::RS_W'({yc_hi_r, {H{1'b0}}});
      ctx2_r  <= ctx1_r;
      root2_r <= root1_r;
    end
  end

  assign out_vld  = vld2_r;
  assign out_ctx  = ctx2_r;
  assign out_root = root2_r;
  assign rs       = rs_r;
  assign pxc      = pxc_r;
  assign pyc      = pyc_r;

endmodule

/* src/rmj_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmj_div
// Pipelined restoring divider: an overflow check on the upper numerator
// bits, then one quotient bit per stage.
// ----------------------------------------------------------------------------
module rmj_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_vld,
  input  logic [rmj_pkg::DIV_NW-1:0]  num,
  input  logic [rmj_pkg::DIV_DW-1:0]  den,
  output logic                        out_vld,
  output logic [rmj_pkg::DIV_QW-1:0]  quo,
  output logic                        ovf
);

  localparam int N  = rmj_pkg::DIV_QW;
  localparam int DW = rmj_pkg::DIV_DW;
  localparam int HW = rmj_pkg::DIV_HW;

  logic [N:0]        vld_r;
  logic [DW:0]       rem_r  [N+1];
  logic [DW:0]       rem_nxt[N+1];
  logic [N-1:0]      low_r  [N+1];
  logic [N-1:0]      low_nxt[N+1];
  logic [DW-1:0]     den_r  [N+1];
  logic [N:0]        ovf_r;

  always_comb begin
    logic [DW:0] cur;
    logic        qb;
    // The quotient fits in N bits only if the upper numerator part is below den.
    rem_nxt[0] = (DW+1)'(num[rmj_pkg::DIV_NW-1:N]);
    low_nxt[0] = num[N-1:0];
    for (int k = 1; k <= N; k++) begin
      cur = {rem_r[k-1][DW-1:0], low_r[k-1][N-1]};
      qb  = (cur >= {1'b0, den_r[k-1]});
      rem_nxt[k] = qb ? cur - {1'b0, den_r[k-1]} : cur;
      low_nxt[k] = {low_r[k-1][N-2:0], qb};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[N-1:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ovf_r[0] <= (DW'(num[rmj_pkg::DIV_NW-1:N]) >= den);
      den_r[0] <= den;
      for (int k = 0; k <= N; k++) begin
        rem_r[k] <= rem_nxt[k];
        low_r[k] <= low_nxt[k];
      end
      for (int k = 1; k <= N; k++) begin
        ovf_r[k] <= ovf_r[k-1];
        den_r[k] <= den_r[k-1];
      end
    end
  end

  assign out_vld = vld_r[N];
  assign quo     = low_r[N];
  assign ovf     = ovf_r[N] | (HW > DW);

endmodule

/* src/radar_measurement_jacobian.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radar_measurement_jacobian
// Pipeline order: front, square root, wide products, dividers, output register.
// Throughput: one beat per cycle; the whole pipeline advances whenever the
// output register is empty or being taken.
// Reset clears all valid bits and sets the squared-range threshold to 655.
// ----------------------------------------------------------------------------
module radar_measurement_jacobian (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [95:0]  in_tdata,   // pos_x, pos_y, vel_x, vel_y (24 bits each)
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [191:0] out_tdata,  // range_dx, range_dy, bearing_dx, bearing_dy,
                                   // rate_dx, rate_dy (32 bits each)
  output logic [1:0]   out_tuser,  // singular, saturated
  input  logic         cfg_wr_en,
  input  logic [15:0]  cfg_wr_data
);

  localparam int IW = rmj_pkg::IN_W;
  localparam int OW = rmj_pkg::OUT_W;
  localparam int NE = rmj_pkg::N_ENT;

  logic                       en;
  logic [rmj_pkg::CFG_W-1:0]  thr_r;

  logic signed [IW-1:0] pos_x, pos_y, vel_x, vel_y;

  logic                       fr_vld, sq_vld, mu_vld;
  rmj_pkg::ctx_t              fr_ctx, sq_ctx, mu_ctx;
  logic [rmj_pkg::R_W-1:0]    sq_root, mu_root;
  logic [rmj_pkg::RS_W-1:0]   mu_rs, mu_pxc, mu_pyc;

  logic [rmj_pkg::DIV_NW-1:0] num_c [NE];
  logic [rmj_pkg::DIV_DW-1:0] den_c [NE];
  logic [rmj_pkg::DIV_QW-1:0] quo   [NE];
  logic [NE-1:0]              ovf, dv_vld;

  logic [NE:0]                side_c;
  logic [NE:0]                side_r [rmj_pkg::DIV_LAT];

  logic                       out_tvalid_r;
  logic [NE*OW-1:0]           out_tdata_r, out_tdata_nxt;
  logic [1:0]                 out_tuser_r, out_tuser_nxt;

  assign en        = !out_tvalid_r || out_tready;
  assign in_tready = en;

  assign pos_x = in_tdata[IW-1:0];
  assign pos_y = in_tdata[2*IW-1:IW];
  assign vel_x = in_tdata[3*IW-1:2*IW];
  assign vel_y = in_tdata[4*IW-1:3*IW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= rmj_pkg::CFG_RESET;
    end else if (cfg_wr_en) begin
      thr_r <= cfg_wr_data;
    end
  end

  rmj_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_vld (in_tvalid),
    .pos_x  (pos_x),
    .pos_y  (pos_y),
    .vel_x  (vel_x),
    .vel_y  (vel_y),
    .thr    (thr_r),
    .out_vld(fr_vld),
    .out_ctx(fr_ctx)
  );

  rmj_sqrt u_sqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_vld (fr_vld),
    .in_ctx (fr_ctx),
    .out_vld(sq_vld),
    .out_ctx(sq_ctx),
    .root   (sq_root)
  );

  rmj_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (sq_vld),
    .in_ctx  (sq_ctx),
    .in_root (sq_root),
    .out_vld (mu_vld),
    .out_ctx (mu_ctx),
    .out_root(mu_root),
    .rs      (mu_rs),
    .pxc     (mu_pxc),
    .pyc     (mu_pyc)
  );

  // Numerators carry the fixed-point scaling; denominators are R, S or R*S.
  always_comb begin
    num_c[0] = rmj_pkg::DIV_NW'({mu_ctx.mx, {rmj_pkg::FRAC{1'b0}}});
    num_c[1] = rmj_pkg::DIV_NW'({mu_ctx.my, {rmj_pkg::FRAC{1'b0}}});
    num_c[2] = rmj_pkg::DIV_NW'({mu_ctx.my, {(2*rmj_pkg::FRAC){1'b0}}});
    num_c[3] = rmj_pkg::DIV_NW'({mu_ctx.mx, {(2*rmj_pkg::FRAC){1'b0}}});
    num_c[4] = rmj_pkg::DIV_NW'({mu_pyc, {rmj_pkg::FRAC{1'b0}}});
    num_c[5] = rmj_pkg::DIV_NW'({mu_pxc, {rmj_pkg::FRAC{1'b0}}});
    den_c[0] = rmj_pkg::DIV_DW'(mu_root);
    den_c[1] = rmj_pkg::DIV_DW'(mu_root);
    den_c[2] = rmj_pkg::DIV_DW'(mu_ctx.s);
    den_c[3] = rmj_pkg::DIV_DW'(mu_ctx.s);
    den_c[4] = mu_rs;
    den_c[5] = mu_rs;
    side_c[0] = mu_ctx.px_neg;
    side_c[1] = mu_ctx.py_neg;
    side_c[2] = !mu_ctx.py_neg && (mu_ctx.my != '0);
    side_c[3] = mu_ctx.px_neg;
    side_c[4] = mu_ctx.py_neg ^ mu_ctx.cneg;
    side_c[5] = mu_ctx.px_neg ^ !mu_ctx.cneg;
    side_c[NE] = mu_ctx.sing;
  end

  for (genvar j = 0; j < NE; j++) begin : g_div
    rmj_div u_div (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .in_vld (mu_vld),
      .num    (num_c[j]),
      .den    (den_c[j]),
      .out_vld(dv_vld[j]),
      .quo    (quo[j]),
      .ovf    (ovf[j])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_c;
      for (int k = 1; k < rmj_pkg::DIV_LAT; k++) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  // Apply the sign and clip to the output range; a singular beat is zeroed and flagged instead.
  always_comb begin
    logic          neg, clip;
    logic [OW-1:0] lim, v;
    logic          sat;
    sat = 1'b0;
    out_tdata_nxt = '0;
    for (int j = 0; j < NE; j++) begin
      neg  = side_r[rmj_pkg::DIV_LAT-1][j];
      lim  = {neg, {(OW-1){~neg}}};
      clip = ovf[j] || (quo[j] > lim);
      v    = clip ? lim : quo[j];
      v    = neg ? -v : v;
      sat  = sat | clip;
      out_tdata_nxt[j*OW +: OW] = v;
    end
    if (side_r[rmj_pkg::DIV_LAT-1][NE]) begin
      out_tdata_nxt = '0;
      out_tuser_nxt = 2'b01;
    end else begin
      out_tuser_nxt = {sat, 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (en) begin
      out_tvalid_r <= &dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tdata_r <= out_tdata_nxt;
      out_tuser_r <= out_tuser_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // The six dividers run in lock step.
  a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    (dv_vld == '0) || (dv_vld == '1))
    else $error("divider valid bits disagree");

  // A singular beat carries only zero entries and never a clip flag.
  a_sing_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> (out_tdata == '0) && !out_tuser[1])
    else $error("singular beat with nonzero content");

  // A stalled output freezes the divider pipeline.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(dv_vld))
    else $error("pipeline moved during output stall");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule
